>>> design/ccrc_pkg.sv
package ccrc_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned DataW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OrderW  = 6;
  localparam int unsigned CfgIdxW = 3;

  // Default for the largest supported CRC order.
  localparam int unsigned MaxOrderDefault = 32;

  // Register map of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    REG_ORDER,
    REG_POLY,
    REG_INIT,
    REG_INIT_DIRECT,
    REG_XOR_OUT,
    REG_REFLECT_IN,
    REG_REFLECT_OUT
  } ccrc_reg_e;

  // Register values after reset.
  localparam logic [OrderW-1:0] RstOrder      = 6'd16;
  localparam logic [DataW-1:0]  RstPoly       = 32'h0000_1021;
  localparam logic [DataW-1:0]  RstInit       = 32'h0000_FFFF;
  localparam logic              RstInitDirect = 1'b1;
  localparam logic [DataW-1:0]  RstXorOut     = 32'h0000_0000;

  // One input request as held in the input stage.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             has_byte;
    logic             first;
    logic             last;
  } ccrc_item_t;

  // Bit order controls.
  typedef struct packed {
    logic reflect_in;
    logic reflect_out;
  } ccrc_flags_t;

endpackage

>>> design/ccrc_if.sv
// Input stream: one message byte with framing flags.
interface ccrc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ccrc_pkg::ByteW-1:0]  data_byte;
  logic                        has_byte;
  logic                        first;
  logic                        last;

  modport source (output valid, data_byte, has_byte, first, last, input ready);
  modport sink   (input valid, data_byte, has_byte, first, last, output ready);
endinterface

// Result stream: one finished CRC per message.
interface ccrc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ccrc_pkg::DataW-1:0]  crc_value;

  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

// Configuration write channel.
interface ccrc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ccrc_pkg::CfgIdxW-1:0]  index;
  logic [ccrc_pkg::DataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/ccrc_shift8.sv
// Eight unrolled shift steps of a CRC held MSB aligned, one input bit each.
// Step k runs only when its enable bit is set; bits are taken MSB first.
module ccrc_shift8 #(
  parameter int unsigned Width = 32
) (
  input  logic [Width-1:0] state_i,
  input  logic [7:0]       bits_i,
  input  logic [Width-1:0] poly_i,
  input  logic [7:0]       en_i,
  output logic [Width-1:0] state_o
);

  // Top bit XOR input bit selects the polynomial feedback.
  always_comb begin
    logic [Width-1:0] r;
    logic             fb;
    r = state_i;
    for (int k = 0; k < 8; k++) begin
      fb = r[Width-1] ^ bits_i[7-k];
      if (en_i[k]) begin
        r = {r[Width-2:0], 1'b0} ^ (fb ? poly_i : '0);
      end
    end
    state_o = r;
  end

endmodule

>>> design/ccrc_prep.sv
// Prepares the aligned polynomial and the start value of the CRC register
// after reset and after every configuration write. A non-direct initial
// value is shifted forward order times with zero input, eight steps a cycle.
module ccrc_prep #(
  parameter int unsigned Width = 32,
  parameter int unsigned OrdW  = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic [Width-1:0] poly_i,
  input  logic [Width-1:0] init_i,
  input  logic             direct_i,
  input  logic [OrdW-1:0]  order_i,
  input  logic [OrdW-1:0]  shift_i,
  output logic [Width-1:0] poly_al_o,
  output logic [Width-1:0] init_al_o,
  output logic             busy_o
);

  localparam int unsigned StepN = 8;
  localparam int unsigned CntW  = $clog2(Width + 2 * StepN);

  typedef enum logic [1:0] {
    PREP_LOAD,
    PREP_RUN,
    PREP_DONE
  } prep_state_e;

  prep_state_e      state_q;
  logic [CntW-1:0]  cnt_q;
  logic [Width-1:0] poly_q;
  logic [Width-1:0] reg_q;
  logic [CntW-1:0]  limit;
  logic [7:0]       step_en;
  logic [Width-1:0] reg_next;

  // A direct value needs no shift steps at all.
  assign limit = direct_i ? '0 : CntW'(order_i);

  // Enable only the clocks that are still due.
  always_comb begin
    for (int k = 0; k < StepN; k++) begin
      step_en[k] = (cnt_q + CntW'(k)) < limit;
    end
  end

  ccrc_shift8 #(
    .Width (Width)
  ) u_shift (
    .state_i (reg_q),
    .bits_i  (8'h00),
    .poly_i  (poly_q),
    .en_i    (step_en),
    .state_o (reg_next)
  );

  // Sequencer: load aligned values, then clock until the count is reached.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PREP_LOAD;
      cnt_q   <= '0;
      poly_q  <= '0;
      reg_q   <= '0;
    end else if (restart_i) begin
      state_q <= PREP_LOAD;
    end else begin
      unique case (state_q)
        PREP_LOAD: begin
          poly_q  <= poly_i << shift_i;
          reg_q   <= init_i << shift_i;
          cnt_q   <= '0;
          state_q <= PREP_RUN;
        end
        PREP_RUN: begin
          if (cnt_q >= limit) begin
            state_q <= PREP_DONE;
          end else begin
            reg_q <= reg_next;
            cnt_q <= cnt_q + CntW'(StepN);
          end
        end
        PREP_DONE: begin
          state_q <= PREP_DONE;
        end
        default: begin
          state_q <= PREP_LOAD;
        end
      endcase
    end
  end

  assign poly_al_o = poly_q;
  assign init_al_o = reg_q;
  assign busy_o    = (state_q != PREP_DONE);

endmodule

>>> design/ccrc_core.sv
// Byte datapath: input register, one byte of CRC update, result register.
// The running CRC is kept MSB aligned in Width bits; the low bits below the
// order stay zero.
module ccrc_core #(
  parameter int unsigned Width = 32,
  parameter int unsigned OrdW  = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ccrc_in_if.sink               in_i,
  ccrc_out_if.source            out_o,
  input  logic                  busy_i,
  input  logic [Width-1:0]      poly_al_i,
  input  logic [Width-1:0]      init_al_i,
  input  ccrc_pkg::ccrc_flags_t flags_i,
  input  logic [Width-1:0]      xor_out_i,
  input  logic [OrdW-1:0]       shift_i,
  input  logic                  realign_i,
  input  logic [OrdW-1:0]       new_shift_i
);

  ccrc_pkg::ccrc_item_t in_item;
  ccrc_pkg::ccrc_item_t s1_item_q;
  logic                 s1_valid_q;
  logic                 s1_adv;
  logic                 in_accept;
  logic [Width-1:0]     crc_q;
  logic [Width-1:0]     crc_base;
  logic [Width-1:0]     crc_next;
  logic [Width-1:0]     crc_rev;
  logic [Width-1:0]     res_raw;
  logic [Width-1:0]     res;
  logic [Width-1:0]     mask;
  logic [7:0]           byte_bits;
  logic [7:0]           byte_en;
  logic                 out_valid_q;
  logic [Width-1:0]     out_crc_q;

  assign in_item = '{
    data_byte: in_i.data_byte,
    has_byte:  in_i.has_byte,
    first:     in_i.first,
    last:      in_i.last
  };

  // The stage moves on unless it holds a result and the output slot is full.
  assign s1_adv    = s1_valid_q && (!s1_item_q.last || !out_valid_q || out_o.ready);
  assign in_i.ready = !busy_i && (!s1_valid_q || s1_adv);
  assign in_accept = in_i.valid && in_i.ready;

  // Byte and start value selection.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      byte_bits[k] = flags_i.reflect_in ? s1_item_q.data_byte[7-k]
                                        : s1_item_q.data_byte[k];
    end
    byte_en  = s1_item_q.has_byte ? 8'hFF : 8'h00;
    crc_base = s1_item_q.first ? init_al_i : crc_q;
  end

  ccrc_shift8 #(
    .Width (Width)
  ) u_shift (
    .state_i (crc_base),
    .bits_i  (byte_bits),
    .poly_i  (poly_al_i),
    .en_i    (byte_en),
    .state_o (crc_next)
  );

  // Final value: reversing the aligned word gives the reflected CRC right
  // aligned; otherwise shift it down to the order.
  always_comb begin
    for (int k = 0; k < Width; k++) begin
      crc_rev[k] = crc_next[Width-1-k];
    end
    mask    = {Width{1'b1}} >> shift_i;
    res_raw = flags_i.reflect_out ? crc_rev : (crc_next >> shift_i);
    res     = (res_raw ^ xor_out_i) & mask;
  end

  // Control registers and the running CRC.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      crc_q       <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv && s1_item_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // An order change moves the register to its new alignment and drops
      // the bits above the new order.
      if (s1_adv) begin
        crc_q <= crc_next;
      end else if (realign_i) begin
        crc_q <= (crc_q >> shift_i) << new_shift_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item;
    end
    if (s1_adv && s1_item_q.last) begin
      out_crc_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.crc_value = ccrc_pkg::DataW'(out_crc_q);

endmodule

>>> design/configurable_crc_engine.sv
// Configurable CRC engine, one message byte per request.
// Channels: in_i carries data_byte, has_byte, first and last; out_o carries
// one crc_value for every request with last set; cfg_i writes the registers
// order, poly, init_value, init_is_direct, xor_out, reflect_in and
// reflect_out by index. cfg_i is always ready.
// Throughput is one request per cycle while neither stall below holds: a
// request is registered, its byte is folded into the running CRC by eight
// unrolled shift steps in the input stage, and the result of a request
// with last is then registered in the output register. After reset and
// after each configuration write the preparation sequencer aligns the
// polynomial and initial value and, for a non-direct initial value, clocks
// it forward eight steps a cycle; in_i is not ready meanwhile, through the
// load and run states of the sequencer.
// Reset loads the default CRC-16 settings and clears the running CRC.
// When out_o stalls, requests without last still flow; a request with last
// waits in the input stage and in_i drops ready until the result is taken.
module configurable_crc_engine #(
  parameter int unsigned MaxOrder = ccrc_pkg::MaxOrderDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccrc_in_if.sink     in_i,
  ccrc_out_if.source  out_o,
  ccrc_cfg_if.sink    cfg_i
);

  localparam int unsigned CrcW = (MaxOrder < ccrc_pkg::DataW) ? MaxOrder : ccrc_pkg::DataW;
  localparam int unsigned OrdW = $clog2(CrcW + 1);

  logic [ccrc_pkg::OrderW-1:0] order_q;
  logic [ccrc_pkg::DataW-1:0]  poly_q;
  logic [ccrc_pkg::DataW-1:0]  init_q;
  logic                        init_direct_q;
  logic [ccrc_pkg::DataW-1:0]  xor_out_q;
  ccrc_pkg::ccrc_flags_t       flags_q;
  logic                        cfg_accept;
  logic [OrdW-1:0]             order_eff;
  logic [OrdW-1:0]             shift_amt;
  logic [OrdW-1:0]             new_shift;
  logic                        realign;
  logic                        prep_busy;
  logic [CrcW-1:0]             poly_al;
  logic [CrcW-1:0]             init_al;

  // Zero counts as one; anything above the supported width saturates.
  function automatic logic [OrdW-1:0] eff_order(input logic [ccrc_pkg::OrderW-1:0] raw);
    logic [OrdW-1:0] o;
    if (raw == '0) begin
      o = OrdW'(1);
    end else if (raw > ccrc_pkg::OrderW'(CrcW)) begin
      o = OrdW'(CrcW);
    end else begin
      o = OrdW'(raw);
    end
    return o;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cfg_accept  = cfg_i.valid && cfg_i.ready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q       <= ccrc_pkg::RstOrder;
      poly_q        <= ccrc_pkg::RstPoly;
      init_q        <= ccrc_pkg::RstInit;
      init_direct_q <= ccrc_pkg::RstInitDirect;
      xor_out_q     <= ccrc_pkg::RstXorOut;
      flags_q       <= '0;
    end else if (cfg_accept) begin
      unique case (cfg_i.index)
        ccrc_pkg::REG_ORDER:       order_q             <= cfg_i.data[ccrc_pkg::OrderW-1:0];
        ccrc_pkg::REG_POLY:        poly_q              <= cfg_i.data;
        ccrc_pkg::REG_INIT:        init_q              <= cfg_i.data;
        ccrc_pkg::REG_INIT_DIRECT: init_direct_q       <= cfg_i.data[0];
        ccrc_pkg::REG_XOR_OUT:     xor_out_q           <= cfg_i.data;
        ccrc_pkg::REG_REFLECT_IN:  flags_q.reflect_in  <= cfg_i.data[0];
        ccrc_pkg::REG_REFLECT_OUT: flags_q.reflect_out <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // Alignment of the order inside the CRC word, now and after a write.
  assign order_eff = eff_order(order_q);
  assign shift_amt = OrdW'(CrcW) - order_eff;
  assign new_shift = OrdW'(CrcW) - eff_order(cfg_i.data[ccrc_pkg::OrderW-1:0]);
  assign realign   = cfg_accept && (cfg_i.index == ccrc_pkg::REG_ORDER);

  ccrc_prep #(
    .Width (CrcW),
    .OrdW  (OrdW)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_accept),
    .poly_i    (poly_q[CrcW-1:0]),
    .init_i    (init_q[CrcW-1:0]),
    .direct_i  (init_direct_q),
    .order_i   (order_eff),
    .shift_i   (shift_amt),
    .poly_al_o (poly_al),
    .init_al_o (init_al),
    .busy_o    (prep_busy)
  );

  ccrc_core #(
    .Width (CrcW),
    .OrdW  (OrdW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .busy_i      (prep_busy),
    .poly_al_i   (poly_al),
    .init_al_i   (init_al),
    .flags_i     (flags_q),
    .xor_out_i   (xor_out_q[CrcW-1:0]),
    .shift_i     (shift_amt),
    .realign_i   (realign),
    .new_shift_i (new_shift)
  );

  // A configuration write always holds off requests while values are prepared.
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready) |=> !in_i.ready)
    else $error("request channel ready right after a configuration write");

  // A message end reaches out_o through the input stage and output register.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last) |-> ##2 out_o.valid)
    else $error("no result pending two cycles after a message end");

endmodule

>>> test/crc_result_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register channels of the CRC engine, keeps
// its own copy of the settings and of the running CRC, and compares every
// finished CRC with the oldest one it has computed.
module crc_result_checker #(
  parameter int unsigned MaxOrder = ccrc_pkg::MaxOrderDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ccrc_in_if          req_mon_i,
  ccrc_out_if         crc_mon_i,
  ccrc_cfg_if         cfg_mon_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);

  // Mirror of the register file and of the running CRC.
  logic [ccrc_pkg::OrderW-1:0] order_q;
  logic [ccrc_pkg::DataW-1:0]  poly_q;
  logic [ccrc_pkg::DataW-1:0]  init_q;
  logic                        init_direct_q;
  logic [ccrc_pkg::DataW-1:0]  xor_out_q;
  ccrc_pkg::ccrc_flags_t       flags_q;
  logic [ccrc_pkg::DataW-1:0]  crc_q;

  logic [ccrc_pkg::DataW-1:0]  expected_crcs[$];
  int unsigned                 mismatches;

  assign err_count_o = mismatches;
  assign pending_o   = expected_crcs.size();

  // Order in use: zero counts as one, large values saturate.
  function automatic int unsigned active_order();
    int unsigned o;
    int unsigned ceiling;
    o = int'(order_q);
    ceiling = (MaxOrder < 32) ? MaxOrder : 32;
    if (o < 1) o = 1;
    if (o > ceiling) o = ceiling;
    return o;
  endfunction

  function automatic logic [ccrc_pkg::DataW-1:0] width_mask(int unsigned o);
    return (o >= 32) ? '1 : ((32'h1 << o) - 32'h1);
  endfunction

  function automatic logic [ccrc_pkg::DataW-1:0] mirror_bits(logic [ccrc_pkg::DataW-1:0] v,
                                                             int unsigned nbits);
    logic [ccrc_pkg::DataW-1:0] r;
    r = '0;
    for (int k = 0; k < nbits; k++) begin
      r = {r[ccrc_pkg::DataW-2:0], v[0]};
      v = v >> 1;
    end
    return r;
  endfunction

  // One clock of the shift register; the input bit and the top bit decide the feedback.
  function automatic logic [ccrc_pkg::DataW-1:0] shift_bit(logic [ccrc_pkg::DataW-1:0] acc,
                                                           logic in_bit, int unsigned o);
    logic [ccrc_pkg::DataW-1:0] m;
    logic                       msb;
    m = width_mask(o);
    msb = acc[o-1];
    acc = (acc << 1) & m;
    if (msb ^ in_bit) acc = acc ^ (poly_q & m);
    return acc;
  endfunction

  // Folds one request into the running CRC: load, byte, then emit.
  function automatic void fold_request(input ccrc_pkg::ccrc_item_t req, output logic emit,
                                       output logic [ccrc_pkg::DataW-1:0] crc_out);
    int unsigned                o;
    logic [ccrc_pkg::DataW-1:0] m;
    logic [ccrc_pkg::DataW-1:0] seed;
    logic [ccrc_pkg::DataW-1:0] byte_bits;
    logic [ccrc_pkg::DataW-1:0] final_crc;
    o = active_order();
    m = width_mask(o);
    crc_q = crc_q & m;
    if (req.first) begin
      seed = init_q & m;
      if (!init_direct_q) begin
        for (int k = 0; k < o; k++) seed = shift_bit(seed, 1'b0, o);
      end
      crc_q = seed;
    end
    if (req.has_byte) begin
      byte_bits = {24'h0, req.data_byte};
      if (flags_q.reflect_in) byte_bits = mirror_bits(byte_bits, ccrc_pkg::ByteW);
      for (int k = 0; k < ccrc_pkg::ByteW; k++) begin
        crc_q = shift_bit(crc_q, byte_bits[ccrc_pkg::ByteW-1-k], o);
      end
    end
    final_crc = crc_q;
    if (flags_q.reflect_out) final_crc = mirror_bits(final_crc, o);
    emit = req.last;
    crc_out = (final_crc ^ xor_out_q) & m;
  endfunction

  // Sample all three channels at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    ccrc_pkg::ccrc_item_t       req;
    logic                       emit;
    logic [ccrc_pkg::DataW-1:0] crc_next;
    logic [ccrc_pkg::DataW-1:0] crc_want;
    if (!rst_ni) begin
      order_q       = ccrc_pkg::RstOrder;
      poly_q        = ccrc_pkg::RstPoly;
      init_q        = ccrc_pkg::RstInit;
      init_direct_q = ccrc_pkg::RstInitDirect;
      xor_out_q     = ccrc_pkg::RstXorOut;
      flags_q       = '0;
      crc_q         = '0;
      mismatches    = 0;
      expected_crcs.delete();
    end else begin
      // Register writes take effect at once.
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (ccrc_pkg::ccrc_reg_e'(cfg_mon_i.index))
          ccrc_pkg::REG_ORDER:       order_q = cfg_mon_i.data[ccrc_pkg::OrderW-1:0];
          ccrc_pkg::REG_POLY:        poly_q = cfg_mon_i.data;
          ccrc_pkg::REG_INIT:        init_q = cfg_mon_i.data;
          ccrc_pkg::REG_INIT_DIRECT: init_direct_q = cfg_mon_i.data[0];
          ccrc_pkg::REG_XOR_OUT:     xor_out_q = cfg_mon_i.data;
          ccrc_pkg::REG_REFLECT_IN:  flags_q.reflect_in = cfg_mon_i.data[0];
          ccrc_pkg::REG_REFLECT_OUT: flags_q.reflect_out = cfg_mon_i.data[0];
          default: ;
        endcase
      end

      // A finished CRC is matched with the oldest prediction.
      if (crc_mon_i.valid && crc_mon_i.ready) begin
        if (expected_crcs.size() == 0) begin
          $error("crc_value: unexpected result %0h with no request waiting",
                 crc_mon_i.crc_value);
          mismatches++;
        end else begin
          crc_want = expected_crcs.pop_front();
          if (crc_mon_i.crc_value !== crc_want) begin
            $error("crc_value mismatch: expected %0h, actual %0h",
                   crc_want, crc_mon_i.crc_value);
            mismatches++;
          end
        end
      end

      // Every accepted request advances the prediction.
      if (req_mon_i.valid && req_mon_i.ready) begin
        req.data_byte = req_mon_i.data_byte;
        req.has_byte  = req_mon_i.has_byte;
        req.first     = req_mon_i.first;
        req.last      = req_mon_i.last;
        fold_request(req, emit, crc_next);
        if (emit) expected_crcs.push_back(crc_next);
      end
    end
  end

endmodule

>>> test/configurable_crc_engine_tb.sv
`timescale 1ns / 100ps

// Drives message streams and register settings into the CRC engine and gives
// the verdict from the failure count and the pending count of the checker.
module configurable_crc_engine_tb;

  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ItemW         = $bits(ccrc_pkg::ccrc_item_t);

  // Index past the end of the register map; writes to it are dropped.
  localparam logic [ccrc_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned crc_pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  ccrc_in_if  req_bus ();
  ccrc_out_if crc_bus ();
  ccrc_cfg_if cfg_bus ();

  configurable_crc_engine DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_bus),
    .out_o  (crc_bus),
    .cfg_i  (cfg_bus)
  );

  crc_result_checker checker_inst (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_mon_i   (req_bus),
    .crc_mon_i   (crc_bus),
    .cfg_mon_i   (cfg_bus),
    .err_count_o (mismatch_count),
    .pending_o   (crc_pending)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: ready drops at random at the configured rate.
  initial begin
    crc_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      crc_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Ends the run when no channel moves anything for too long.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (crc_bus.valid && crc_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Offers one request after a random gap and waits until it is taken.
  task automatic push_request(input ccrc_pkg::ccrc_item_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.data_byte <= req.data_byte;
    req_bus.has_byte  <= req.has_byte;
    req_bus.first     <= req.first;
    req_bus.last      <= req.last;
    do @(posedge clk); while (!req_bus.ready);
    @(negedge clk);
  endtask

  task automatic push_fields(input logic [ccrc_pkg::ByteW-1:0] b, input logic has,
                             input logic sof, input logic eof);
    ccrc_pkg::ccrc_item_t req;
    req.data_byte = b;
    req.has_byte  = has;
    req.first     = sof;
    req.last      = eof;
    push_request(req);
  endtask

  // Holds the sender back until every expected CRC has come out.
  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    do @(negedge clk); while (crc_pending != 0);
  endtask

  // Back-to-back register writes keep valid high; the caller lowers it.
  task automatic write_reg(input logic [ccrc_pkg::CfgIdxW-1:0] idx,
                           input logic [ccrc_pkg::DataW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  // Writes the whole register map while the engine is idle.
  task automatic load_settings(input logic [ccrc_pkg::DataW-1:0] order_v,
                               input logic [ccrc_pkg::DataW-1:0] poly_v,
                               input logic [ccrc_pkg::DataW-1:0] init_v,
                               input logic [ccrc_pkg::DataW-1:0] direct_v,
                               input logic [ccrc_pkg::DataW-1:0] xor_v,
                               input logic [ccrc_pkg::DataW-1:0] rin_v,
                               input logic [ccrc_pkg::DataW-1:0] rout_v);
    wait_for_results();
    repeat (SettleCycles) @(negedge clk);
    write_reg(ccrc_pkg::REG_ORDER, order_v);
    write_reg(ccrc_pkg::REG_POLY, poly_v);
    write_reg(ccrc_pkg::REG_INIT, init_v);
    write_reg(ccrc_pkg::REG_INIT_DIRECT, direct_v);
    write_reg(ccrc_pkg::REG_XOR_OUT, xor_v);
    write_reg(ccrc_pkg::REG_REFLECT_IN, rin_v);
    write_reg(ccrc_pkg::REG_REFLECT_OUT, rout_v);
    write_reg(RegUnused, $urandom());
    cfg_bus.valid <= 1'b0;
  endtask

  // A framed message of random bytes; an unclosed one has no last flag.
  task automatic send_message(input int unsigned len, input logic closed);
    ccrc_pkg::ccrc_item_t req;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        push_fields(ccrc_pkg::ByteW'($urandom()), 1'b0, 1'b0, 1'b0);
      end
      req.data_byte = ccrc_pkg::ByteW'($urandom());
      req.has_byte  = 1'b1;
      req.first     = (i == 0);
      req.last      = closed && (i == len - 1);
      push_request(req);
    end
  endtask

  // Short directed sequence under the reset settings.
  task automatic directed_requests();
    // Data before any first continues from the cleared register.
    push_fields(8'hA5, 1'b1, 1'b0, 1'b0);
    push_fields(8'h3C, 1'b1, 1'b0, 1'b1);
    // The usual check string "123456789".
    for (int unsigned i = 0; i < 9; i++) begin
      push_fields(ccrc_pkg::ByteW'(32'h31 + i), 1'b1, (i == 0), (i == 8));
    end
    // Last without a byte, then a message with no byte at all.
    push_fields(8'h00, 1'b0, 1'b0, 1'b1);
    push_fields(8'hFF, 1'b0, 1'b1, 1'b1);
    // Single-byte messages at both byte extremes.
    push_fields(8'h00, 1'b1, 1'b1, 1'b1);
    push_fields(8'hFF, 1'b1, 1'b1, 1'b1);
    // An empty request is ignored.
    push_fields(8'h5A, 1'b0, 1'b0, 1'b0);
    // First without a byte, then the bytes.
    push_fields(8'h11, 1'b0, 1'b1, 1'b0);
    push_fields(8'h80, 1'b1, 1'b0, 1'b0);
    push_fields(8'h01, 1'b1, 1'b0, 1'b1);
  endtask

  // Mostly framed messages, with broken frames and raw noise mixed in.
  task automatic random_traffic(input int unsigned budget);
    int unsigned          sent;
    int unsigned          pick;
    int unsigned          len;
    ccrc_pkg::ccrc_item_t req;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_message(len, 1'b1);
        sent += len;
      end else if (pick < 85) begin
        len = $urandom_range(1, 6);
        send_message(len, 1'b0);
        sent += len;
      end else if (pick < 98) begin
        req = ccrc_pkg::ccrc_item_t'(ItemW'($urandom_range(0, 2047)));
        push_request(req);
        if (req.has_byte || req.first || req.last) sent++;
      end else begin
        wait_for_results();
      end
    end
  endtask

  // Random settings, now and then with an order outside 1..32.
  task automatic random_settings();
    int unsigned                pick;
    logic [ccrc_pkg::DataW-1:0] order_v;
    pick = $urandom_range(0, 9);
    if (pick == 0) order_v = $urandom_range(33, 63);
    else if (pick == 1) order_v = 0;
    else order_v = $urandom_range(1, 32);
    order_v = ($urandom() & ~32'h3F) | order_v;
    load_settings(order_v, $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom());
  endtask

  // Main sequence.
  initial begin
    rst_n             = 1'b0;
    send_idle_pct     = 20;
    recv_idle_pct     = 80;
    req_bus.valid     = 1'b0;
    req_bus.data_byte = '0;
    req_bus.has_byte  = 1'b0;
    req_bus.first     = 1'b0;
    req_bus.last      = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    for (int unsigned p = 0; p < PhaseCount; p++) begin
      if (p < 4) begin
        send_idle_pct = 20;
        recv_idle_pct = 80;
      end else if (p < 8) begin
        send_idle_pct = 80;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: directed_requests();
        1: load_settings(32, 32'h04C1_1DB7, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1);
        2: load_settings(1, 32'h0000_0001, 32'h0000_0001, 0, 0, 0, 1);
        3: load_settings(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0);
        4: load_settings(63, 0, 0, 0, 0, 1, 0);
        5: load_settings(8, 32'h0000_0007, 32'hFFFF_FFFF, 0, 32'h0000_0055, 1, 0);
        6: load_settings(16, 32'h0000_8005, 32'h0000_1D0F, 0, 0, 1, 1);
        default: random_settings();
      endcase
      random_traffic(ItemsPerPhase);
    end

    // Drain, then allow the pipeline to empty before the verdict.
    wait_for_results();
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0 && crc_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
